FILE: rtl/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared types and constants of the motor and servo command framer.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam int NUM_BYTES  = 19;
  localparam int BCD_CELLS  = 8;
  localparam int PKT_LEN    = 11;
  localparam int PKT_LAST   = PKT_LEN - 1;

  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] PKT_HDR  = 8'hff;
  localparam logic [7:0] PKT_LEN_BYTE = 8'h07;
  localparam logic [7:0] PKT_WRITE    = 8'h03;

  typedef struct packed {
    logic        neg;
    logic [15:0] pos;
    logic [19:0] bcd;
    logic [15:0] bin;
  } bcd_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       fend;
    logic       last;
  } byte_word_t;

endpackage

FILE: rtl/msf_bcd_cell.sv
// ----------------------------------------------------------------------------
// msf_bcd_cell
// One cell of the conversion row: two shift-and-add-3 steps per cycle while en is high.
// ----------------------------------------------------------------------------
module msf_bcd_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  msf_pkg::bcd_word_t in_word,
  output logic              out_vld,
  output msf_pkg::bcd_word_t out_word
);

  function automatic logic [35:0] dd_step(input logic [35:0] v);
    logic [35:0] t;
    t = v;
    for (int d = 0; d < 5; d++) begin
      if (t[16 + 4*d +: 4] >= 4'd5) begin
        t[16 + 4*d +: 4] = t[16 + 4*d +: 4] + 4'd3;
      end
    end
    return {t[34:0], 1'b0};
  endfunction

  logic              vld_r;
  msf_pkg::bcd_word_t word_r;
  msf_pkg::bcd_word_t word_nxt;
  logic [35:0]       step1;
  logic [35:0]       step2;

  always_comb begin
    step1        = dd_step({in_word.bcd, in_word.bin});
    step2        = dd_step(step1);
    word_nxt     = in_word;
    word_nxt.bcd = step2[35:16];
    word_nxt.bin = step2[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

FILE: rtl/msf_byte_cell.sv
// ----------------------------------------------------------------------------
// msf_byte_cell
// One cell of the output row: holds a byte, loads a frame or takes its
// neighbor's byte.
// ----------------------------------------------------------------------------
module msf_byte_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               shift,
  input  logic               load_vld,
  input  msf_pkg::byte_word_t load_word,
  input  logic               next_vld,
  input  msf_pkg::byte_word_t next_word,
  output logic               cell_vld,
  output msf_pkg::byte_word_t cell_word
);

  logic               vld_r;
  msf_pkg::byte_word_t word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= load_vld;
    end else if (shift) begin
      vld_r <= next_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= load_word;
    end else if (shift) begin
      word_r <= next_word;
    end
  end

  assign cell_vld  = vld_r;
  assign cell_word = word_r;

endmodule

FILE: rtl/msf_frame_pack.sv
// ----------------------------------------------------------------------------
// msf_frame_pack
// Lay out the speed text and the servo packet over the byte row.
// ----------------------------------------------------------------------------
module msf_frame_pack (
  input  logic               neg,
  input  logic [15:0]        pos,
  input  logic [19:0]        bcd,
  input  logic [7:0]         servo_id,
  input  logic [7:0]         servo_register,
  input  logic [15:0]        servo_moving_speed,
  output logic               frm_vld  [msf_pkg::NUM_BYTES],
  output msf_pkg::byte_word_t frm_word [msf_pkg::NUM_BYTES]
);

  logic [3:0] g   [5];
  logic [3:0] s   [5];
  logic [7:0] pkt [msf_pkg::PKT_LEN];
  logic [2:0] first;
  logic [2:0] nd;
  logic [2:0] sidx;
  logic [7:0] sum;
  logic [4:0] jj;
  logic [4:0] off;
  logic [4:0] pidx;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      g[k] = bcd[4*(4-k) +: 4];
    end
    priority if (g[0] != 4'd0) first = 3'd0;
    else if (g[1] != 4'd0)     first = 3'd1;
    else if (g[2] != 4'd0)     first = 3'd2;
    else if (g[3] != 4'd0)     first = 3'd3;
    else                       first = 3'd4;
    nd = 3'd5 - first;
    for (int k = 0; k < 5; k++) begin
      sidx = 3'(k) + first;
      s[k] = (sidx < 3'd5) ? g[sidx] : 4'd0;
    end
  end

  always_comb begin
    pkt[0]  = msf_pkg::PKT_HDR;
    pkt[1]  = msf_pkg::PKT_HDR;
    pkt[2]  = servo_id;
    pkt[3]  = msf_pkg::PKT_LEN_BYTE;
    pkt[4]  = msf_pkg::PKT_WRITE;
    pkt[5]  = servo_register;
    pkt[6]  = pos[7:0];
    pkt[7]  = pos[15:8];
    pkt[8]  = servo_moving_speed[7:0];
    pkt[9]  = servo_moving_speed[15:8];
    sum     = pkt[2] + pkt[3] + pkt[4] + pkt[5] + pkt[6] + pkt[7] + pkt[8] + pkt[9];
    pkt[10] = ~sum;
  end

  always_comb begin
    jj   = '0;
    off  = '0;
    pidx = '0;
    for (int j = 0; j < msf_pkg::NUM_BYTES; j++) begin
      jj   = 5'(j);
      off  = jj - {4'd0, neg} - 5'd1;
      pidx = off - {2'd0, nd} - 5'd1;
      frm_vld[j]  = 1'b1;
      frm_word[j] = '0;
      priority if (jj == 5'd0) begin
        frm_word[j].data = msf_pkg::CH_V;
      end else if (neg && jj == 5'd1) begin
        frm_word[j].data = msf_pkg::CH_MINUS;
      end else if (off < {2'd0, nd}) begin
        frm_word[j].data = msf_pkg::CH_ZERO + {4'd0, s[off[2:0]]};
      end else if (off == {2'd0, nd}) begin
        frm_word[j].data = msf_pkg::CH_CR;
        frm_word[j].fend = 1'b1;
      end else if (pidx < 5'(msf_pkg::PKT_LEN)) begin
        frm_word[j].data = pkt[pidx[3:0]];
        frm_word[j].kind = 1'b1;
        frm_word[j].fend = (pidx == 5'(msf_pkg::PKT_LAST));
        frm_word[j].last = (pidx == 5'(msf_pkg::PKT_LAST));
      end else begin
        frm_vld[j] = 1'b0;
      end
    end
  end

endmodule

FILE: rtl/motor_servo_command_framer_core.sv
// ----------------------------------------------------------------------------
// motor_servo_command_framer_core
// Turns a speed and steering command into a speed text frame and a servo
// write packet, one byte per word.
// ----------------------------------------------------------------------------
// Each command gives 14 to 19 output words, one per cycle while out_stall is
// low. A command passes a multiply stage and eight conversion cells (binary
// to decimal, two bits per cell) and is then loaded at once into a row of 19
// byte cells that shifts toward the output, whose head cell presents the
// first word. The byte row takes the next command in the cycle its last word
// leaves, so frames follow each other with no gap and the sustained command
// rate is set by the byte row. Up to nine further commands wait in the
// multiply stage and the conversion cells.
module motor_servo_command_framer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_speed,
  input  logic [15:0] in_steer_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_frame_kind,
  output logic        out_frame_end,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [7:0] {
    CFG_SERVO_ID       = 8'd0,
    CFG_SERVO_REGISTER = 8'd1,
    CFG_MOVING_SPEED   = 8'd2,
    CFG_SPEED_SCALE    = 8'd3
  } cfg_idx_t;

  localparam int NB = msf_pkg::NUM_BYTES;
  localparam int NC = msf_pkg::BCD_CELLS;

  logic [7:0]  servo_id_r;
  logic [7:0]  servo_register_r;
  logic [15:0] moving_speed_r;
  logic [8:0]  speed_scale_r;

  logic               pipe_en;
  logic               load;
  logic               adv;
  logic               front_vld_r;
  msf_pkg::bcd_word_t front_word_r;
  msf_pkg::bcd_word_t front_nxt;
  logic signed [7:0]  spd_clamp;
  logic [6:0]         mag;

  logic               bc_vld  [NC+1];
  msf_pkg::bcd_word_t bc_word [NC+1];

  logic                frm_vld  [NB];
  msf_pkg::byte_word_t frm_word [NB];
  logic                cv       [NB+1];
  msf_pkg::byte_word_t cw       [NB+1];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_id_r       <= 8'd0;
      servo_register_r <= 8'h1e;
      moving_speed_r   <= 16'd512;
      speed_scale_r    <= 9'd120;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SERVO_ID:       servo_id_r       <= cfg_data[7:0];
        CFG_SERVO_REGISTER: servo_register_r <= cfg_data[7:0];
        CFG_MOVING_SPEED:   moving_speed_r   <= cfg_data;
        CFG_SPEED_SCALE:    speed_scale_r    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // clamp and scale
  always_comb begin
    priority if ($signed(in_speed) > 8'sd100) spd_clamp = 8'sd100;
    else if ($signed(in_speed) < -8'sd100)    spd_clamp = -8'sd100;
    else                                       spd_clamp = $signed(in_speed);
    mag           = spd_clamp[7] ? 7'(-spd_clamp) : 7'(spd_clamp);
    front_nxt.neg = spd_clamp[7];
    front_nxt.pos = in_steer_position;
    front_nxt.bcd = '0;
    front_nxt.bin = {9'd0, mag} * {7'd0, speed_scale_r};
  end

  assign pipe_en  = !bc_vld[NC] || load;
  assign in_stall = !pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
    end else if (pipe_en) begin
      front_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && in_valid) begin
      front_word_r <= front_nxt;
    end
  end

  // conversion row
  assign bc_vld[0]  = front_vld_r;
  assign bc_word[0] = front_word_r;

  for (genvar i = 0; i < NC; i++) begin : g_bcd
    msf_bcd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .in_vld   (bc_vld[i]),
      .in_word  (bc_word[i]),
      .out_vld  (bc_vld[i+1]),
      .out_word (bc_word[i+1])
    );
  end

  msf_frame_pack u_pack (
    .neg                (bc_word[NC].neg),
    .pos                (bc_word[NC].pos),
    .bcd                (bc_word[NC].bcd),
    .servo_id           (servo_id_r),
    .servo_register     (servo_register_r),
    .servo_moving_speed (moving_speed_r),
    .frm_vld            (frm_vld),
    .frm_word           (frm_word)
  );

  // byte row
  assign adv  = !cv[0] || !out_stall;
  assign load = bc_vld[NC] && (!cv[0] || (!out_stall && !cv[1]));

  assign cv[NB] = 1'b0;
  assign cw[NB] = '0;

  for (genvar j = 0; j < NB; j++) begin : g_byte
    msf_byte_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (load),
      .shift     (adv),
      .load_vld  (frm_vld[j]),
      .load_word (frm_word[j]),
      .next_vld  (cv[j+1]),
      .next_word (cw[j+1]),
      .cell_vld  (cv[j]),
      .cell_word (cw[j])
    );
  end

  assign out_valid      = cv[0];
  assign out_byte       = cw[0].data;
  assign out_frame_kind = cw[0].kind;
  assign out_frame_end  = cw[0].fend;
  assign out_last       = cw[0].last;

  a_last_is_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_frame_kind && out_frame_end)
    else $error("last word is not a packet frame end");

  a_text_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_kind |-> !out_last)
    else $error("text word flagged as last");

  a_load_fills_head: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid && out_byte == msf_pkg::CH_V)
    else $error("frame load did not present its first byte");

  a_free_pipe_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !bc_vld[NC] |-> !in_stall)
    else $error("input stalled with empty conversion tail");

endmodule
